// ===== rtl/feda_pkg.sv =====
// Shared widths, constants and types for the feedback echo delay block.
package feda_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 7;
  localparam int LEN_W      = 14;
  localparam int ENTRY_W    = 16;
  localparam int OUT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Datapath widths: entry + sample, times gain (max 8,843,010 < 2^24)
  localparam int SUM_W  = 17;
  localparam int PROD_W = 24;

  // Divide by 100 as multiply by ceil(2^31 / 100) and shift; exact below 2^24
  localparam int                 RECIP_W   = 25;
  localparam int                 QUO_W     = PROD_W + RECIP_W;
  localparam int                 DIV_SHIFT = 31;
  localparam logic [RECIP_W-1:0] DIV_MUL   = 25'd21474837;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd50;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 14'd4999;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_LENGTH = 2'd1
  } cfg_reg_t;

  // Advance strobes for the arithmetic stages
  typedef struct packed {
    logic adv1;  // stage 1 moves into stage 2
    logic adv2;  // stage 2 moves into stage 3
  } pipe_ctl_t;

endpackage

// ===== rtl/feda_index.sv =====
// Configuration registers and the circular write index with its wrap logic.
module feda_index #(
  parameter int MAX_DELAY = 8192,
  parameter int AW        = 13
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [feda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [feda_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  output logic [AW-1:0]                   idx,
  output logic [AW-1:0]                   idx_next,
  output logic [feda_pkg::GAIN_W-1:0]     gain
);
  import feda_pkg::*;

  // Compare width: holds both the length register and MAX_DELAY itself
  localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

  logic [LEN_W-1:0] len;
  logic [CW-1:0]    eff_len;
  logic [AW:0]      inc;
  logic             wrap;

  // Length saturates at the store depth; zero behaves like one
  assign eff_len  = (CW'(len) > CW'(MAX_DELAY)) ? CW'(MAX_DELAY) : CW'(len);
  assign inc      = {1'b0, idx} + (AW + 1)'(1);
  assign wrap     = CW'(inc) >= eff_len;
  assign idx_next = wrap ? '0 : inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      len  <= LEN_RESET;
      idx  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN:   gain <= cfg_data[GAIN_W-1:0];
          REG_LENGTH: len  <= cfg_data[LEN_W-1:0];
          default:    ;
        endcase
      end
      if (accept) begin
        idx <= idx_next;
      end
    end
  end

endmodule

// ===== rtl/feda_store.sv =====
// Delay store memory: one write port, two registered read ports, fill mark.
module feda_store #(
  parameter int MAX_DELAY = 8192,
  parameter int AW        = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [feda_pkg::ENTRY_W-1:0]     wr_data,
  input  logic                             a_en,
  input  logic [AW-1:0]                    a_addr,
  output logic [feda_pkg::ENTRY_W-1:0]     a_data,
  output logic                             a_hit,
  input  logic                             b_en,
  input  logic [AW-1:0]                    b_addr,
  output logic [feda_pkg::ENTRY_W-1:0]     b_data,
  output logic                             b_hit
);
  import feda_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_DELAY];

  // Fill mark: entries 0 .. fill-1 have been written, the rest still read as zero.
  // The index only steps by one or returns to zero, so written entries form a prefix.
  logic [AW:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && ({1'b0, wr_addr} >= fill)) begin
      fill <= {1'b0, wr_addr} + (AW + 1)'(1);
    end
  end

  // Memory array and registered reads; hit flags mark entries already written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (a_en) begin
      a_data <= mem[a_addr];
      a_hit  <= {1'b0, a_addr} < fill;
    end
    if (b_en) begin
      b_data <= mem[b_addr];
      b_hit  <= {1'b0, b_addr} < fill;
    end
  end

endmodule

// ===== rtl/feda_scale.sv =====
// Feedback arithmetic: (entry + sample) * gain, then divide by 100, two register stages.
module feda_scale (
  input  logic                          clk,
  input  feda_pkg::pipe_ctl_t           ctl,
  input  logic [feda_pkg::ENTRY_W-1:0]  old_val,
  input  logic [feda_pkg::SAMPLE_W-1:0] sample1,
  input  logic [feda_pkg::GAIN_W-1:0]   gain,
  output logic [feda_pkg::ENTRY_W-1:0]  new_val
);
  import feda_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;

  // Stage 1: add and scale by gain
  assign sum       = SUM_W'(old_val) + SUM_W'(sample1);
  assign prod_next = PROD_W'(sum) * PROD_W'(gain);

  // Stage 2: reciprocal multiply, keep low 16 bits of the quotient
  assign quo = QUO_W'(prod) * QUO_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      prod <= prod_next;
    end
    if (ctl.adv2) begin
      new_val <= quo[DIV_SHIFT +: ENTRY_W];
    end
  end

endmodule

// ===== rtl/feedback_echo_delay_top.sv =====
// Top level of the feedback echo delay: pipeline control, hazard check and output register.
//
// Echo effect with a feedback delay store of MAX_DELAY 16-bit entries. Each input beat
// carries one 12-bit sample and gives one result beat after the store read, gain multiply,
// divide by 100 and the output register. Beats enter one per cycle while the effective
// delay length is four or more and the output is not stalled; with shorter lengths a
// beat waits until no earlier beat that still has to write the same store entry is in
// flight, so the rate falls to length/4 beats per cycle. The store needs no clearing
// pass after reset: a fill mark makes entries not yet written read as zero, so the block
// takes beats right after reset. Configuration writes must come only while no beat is
// in flight.
module feedback_echo_delay_top #(
  parameter int MAX_DELAY = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [feda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [feda_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [feda_pkg::SAMPLE_W-1:0]   sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [feda_pkg::OUT_W-1:0]      out_sample
);
  import feda_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);

  // Stage valids
  logic v1, v2, v3;

  // Stage payloads: sample, own index, next index
  logic [SAMPLE_W-1:0] s1, s2, s3;
  logic [AW-1:0]       i1, i2, i3;
  logic [AW-1:0]       j1, j2, j3;

  // Forwarded entry for the output read
  logic               fwd3;
  logic [ENTRY_W-1:0] fwd_val3;

  logic [AW-1:0]       idx;
  logic [AW-1:0]       idx_next;
  logic [GAIN_W-1:0]   gain;
  logic [ENTRY_W-1:0]  a_data, b_data;
  logic                a_hit, b_hit;
  logic [ENTRY_W-1:0]  old_val;
  logic [ENTRY_W-1:0]  new3;
  logic [ENTRY_W-1:0]  nxt_val;
  pipe_ctl_t           ctl;

  logic accept;
  logic hazard;
  logic out_free, free3, free2, free1;
  logic adv3;

  // Stage flow: a stage moves when the one after it is free
  assign out_free = !out_valid || !out_stall;
  assign adv3     = v3 && out_free;
  assign free3    = !v3 || out_free;
  assign ctl.adv2 = v2 && free3;
  assign free2    = !v2 || free3;
  assign ctl.adv1 = v1 && free2;
  assign free1    = !v1 || free2;

  // Hold the input while an in-flight beat still has to write this beat's entry
  assign hazard   = (v1 && (i1 == idx)) || (v2 && (i2 == idx)) || (v3 && (i3 == idx));
  assign in_stall = !free1 || hazard;
  assign accept   = in_valid && !in_stall;

  feda_index #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .idx       (idx),
    .idx_next  (idx_next),
    .gain      (gain)
  );

  // Port A reads the entry to update, port B the oldest entry for the result
  feda_store #(
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (adv3),
    .wr_addr (i3),
    .wr_data (new3),
    .a_en    (accept),
    .a_addr  (idx),
    .a_data  (a_data),
    .a_hit   (a_hit),
    .b_en    (ctl.adv2),
    .b_addr  (j2),
    .b_data  (b_data),
    .b_hit   (b_hit)
  );

  assign old_val = a_hit ? a_data : '0;

  feda_scale u_scale (
    .clk     (clk),
    .ctl     (ctl),
    .old_val (old_val),
    .sample1 (s1),
    .gain    (gain),
    .new_val (new3)
  );

  // Oldest entry: own update when the index does not move, else the forwarded
  // write of the beat ahead, else the store
  always_comb begin
    if (j3 == i3) begin
      nxt_val = new3;
    end else if (fwd3) begin
      nxt_val = fwd_val3;
    end else if (b_hit) begin
      nxt_val = b_data;
    end else begin
      nxt_val = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= accept;
      end
      if (free2) begin
        v2 <= ctl.adv1;
      end
      if (free3) begin
        v3 <= ctl.adv2;
      end
      if (out_free) begin
        out_valid <= v3;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= sample;
      i1 <= idx;
      j1 <= idx_next;
    end
    if (ctl.adv1) begin
      s2 <= s1;
      i2 <= i1;
      j2 <= j1;
    end
    if (ctl.adv2) begin
      s3       <= s2;
      i3       <= i2;
      j3       <= j2;
      fwd3     <= v3 && (i3 == j2);
      fwd_val3 <= new3;
    end
    if (adv3) begin
      out_sample <= OUT_W'(s3) + OUT_W'(nxt_val);
    end
  end

  // Beats in flight always target distinct store entries
  a_idx_12 : assert property (@(posedge clk) disable iff (rst)
    (v1 && v2) |-> (i1 != i2))
    else $error("stages 1 and 2 hold the same store index");

  a_idx_23 : assert property (@(posedge clk) disable iff (rst)
    (v2 && v3) |-> (i2 != i3))
    else $error("stages 2 and 3 hold the same store index");

  a_idx_13 : assert property (@(posedge clk) disable iff (rst)
    (v1 && v3) |-> (i1 != i3))
    else $error("stages 1 and 3 hold the same store index");

  // The update read never collides with a write in the same cycle
  a_rw_clash : assert property (@(posedge clk) disable iff (rst)
    (accept && adv3) |-> (idx != i3))
    else $error("store read and write hit the same entry in one cycle");

endmodule
